### hdl/date_time_field_editor_core_defines.svh
// Assertion macros used by the date and time field editor core.
`ifndef DATE_TIME_FIELD_EDITOR_CORE_DEFINES_SVH
`define DATE_TIME_FIELD_EDITOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("date_time_field_editor_core: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("date_time_field_editor_core: check failed");

`endif

### hdl/dtfe_pkg.sv
// Types, codes and calendar helpers for the date and time field editor.
package dtfe_pkg;

    typedef enum logic [2:0] {
        OP_SELECT  = 3'd0,
        OP_INC     = 3'd1,
        OP_DEC     = 3'd2,
        OP_LOAD    = 3'd3,
        OP_SAVE    = 3'd4,
        OP_DISCARD = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        FLD_NONE   = 3'd0,
        FLD_HOUR   = 3'd1,
        FLD_MINUTE = 3'd2,
        FLD_SECOND = 3'd3,
        FLD_DATE   = 3'd4,
        FLD_MONTH  = 3'd5,
        FLD_YEAR   = 3'd6
    } t_field;

    typedef enum logic [2:0] {
        CFG_HOUR_MAX   = 3'd0,
        CFG_MINUTE_MAX = 3'd1,
        CFG_SECOND_MAX = 3'd2,
        CFG_DATE_MIN   = 3'd3,
        CFG_MONTH_MIN  = 3'd4,
        CFG_MONTH_MAX  = 3'd5,
        CFG_YEAR_MIN   = 3'd6,
        CFG_YEAR_MAX   = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [6:0]  YEAR_2100  = 7'd100;

    // Packed in the same order as the snapshot word (hour in the top bits).
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] date;
        logic [3:0] month;
        logic [6:0] year;
    } t_time;

    typedef struct packed {
        logic [4:0] hour_max;
        logic [5:0] minute_max;
        logic [5:0] second_max;
        logic [4:0] date_min;
        logic [3:0] month_min;
        logic [3:0] month_max;
        logic [6:0] year_min;
        logic [6:0] year_max;
    } t_limits;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] field_select;
        t_time      load;
    } t_cmd;

    typedef struct packed {
        t_time      tm;
        t_time      snap;
        logic [2:0] sel;
        logic       differs;
        logic       commit;
    } t_step;

    // Gregorian rule on 2000 + yy: 2000 is leap, 2100 is not, else every fourth.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] yy);
        logic leap;
        leap = (yy[1:0] == 2'b00) && (yy != YEAR_2100);
        if (m > MONTH_DEC) begin
            month_len = 5'd0;
        end else if (m == MONTH_FEB) begin
            month_len = leap ? 5'd29 : 5'd28;
        end else begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
                default:                                      month_len = 5'd30;
            endcase
        end
    endfunction

    // Wrapping step: up wraps to lo at or above hi, down wraps to hi at or below lo.
    function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi, input logic up);
        if (up) begin
            wrap_step = (v >= hi) ? lo : v + 7'd1;
        end else begin
            wrap_step = (v <= lo) ? hi : v - 7'd1;
        end
    endfunction

endpackage

### hdl/dtfe_in_if.sv
// Command channel: opcode, field select and the time offered on load.
interface dtfe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [2:0] field_select;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic [4:0] load_date;
    logic [3:0] load_month;
    logic [6:0] load_year;

    modport source (
        output valid, opcode, field_select, load_hour, load_minute, load_second,
               load_date, load_month, load_year,
        input  ready
    );
    modport sink (
        input  valid, opcode, field_select, load_hour, load_minute, load_second,
               load_date, load_month, load_year,
        output ready
    );
endinterface

### hdl/dtfe_out_if.sv
// Result channel: edited time, selected field, changed and commit flags.
interface dtfe_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [5:0] cur_second;
    logic [4:0] cur_date;
    logic [3:0] cur_month;
    logic [6:0] cur_year;
    logic [2:0] cur_field;
    logic       differs;
    logic       commit;

    modport source (
        output valid, cur_hour, cur_minute, cur_second, cur_date, cur_month, cur_year,
               cur_field, differs, commit,
        input  ready
    );
    modport sink (
        input  valid, cur_hour, cur_minute, cur_second, cur_date, cur_month, cur_year,
               cur_field, differs, commit,
        output ready
    );
endinterface

### hdl/dtfe_edit.sv
// Next-state logic for one command: select, wrap edit, date clamp, load and snapshot.
module dtfe_edit
    import dtfe_pkg::*;
(
    input  t_cmd       i_cmd,
    input  t_time      i_time,
    input  t_time      i_snap,
    input  logic [2:0] i_sel,
    input  t_limits    i_lim,
    output t_step      o_step
);

    t_time      edited;
    t_time      nxt_time;
    t_time      nxt_snap;
    logic [2:0] nxt_sel;
    logic       nxt_commit;
    logic       up;
    logic [4:0] clamp_lim;

    // Wrap the selected field, then clamp the date against the new month length.
    always_comb begin
        up        = (t_opcode'(i_cmd.opcode) == OP_INC);
        edited    = i_time;
        clamp_lim = 5'd0;
        case (t_field'(i_sel))
            FLD_HOUR:   edited.hour = 5'(wrap_step({2'd0, i_time.hour}, 7'd0,
                                                   {2'd0, i_lim.hour_max}, up));
            FLD_MINUTE: edited.minute = 6'(wrap_step({1'd0, i_time.minute}, 7'd0,
                                                     {1'd0, i_lim.minute_max}, up));
            FLD_SECOND: edited.second = 6'(wrap_step({1'd0, i_time.second}, 7'd0,
                                                     {1'd0, i_lim.second_max}, up));
            FLD_DATE:   edited.date = 5'(wrap_step({2'd0, i_time.date},
                                                   {2'd0, i_lim.date_min},
                                                   {2'd0, month_len(i_time.month, i_time.year)},
                                                   up));
            FLD_MONTH: begin
                edited.month = 4'(wrap_step({3'd0, i_time.month}, {3'd0, i_lim.month_min},
                                            {3'd0, i_lim.month_max}, up));
                clamp_lim = month_len(edited.month, edited.year);
                if (edited.date > clamp_lim) begin
                    edited.date = clamp_lim;
                end
            end
            FLD_YEAR: begin
                edited.year = wrap_step(i_time.year, i_lim.year_min, i_lim.year_max, up);
                clamp_lim = month_len(edited.month, edited.year);
                if (edited.date > clamp_lim) begin
                    edited.date = clamp_lim;
                end
            end
            default: edited = i_time;
        endcase
    end

    always_comb begin
        nxt_time   = i_time;
        nxt_snap   = i_snap;
        nxt_sel    = i_sel;
        nxt_commit = 1'b0;
        case (t_opcode'(i_cmd.opcode))
            OP_SELECT: begin
                if (i_cmd.field_select <= FLD_YEAR) begin
                    nxt_sel = i_cmd.field_select;
                end
            end
            OP_INC, OP_DEC: nxt_time = edited;
            OP_LOAD: begin
                nxt_time = i_cmd.load;
                nxt_snap = i_cmd.load;
                nxt_sel  = FLD_NONE;
            end
            OP_SAVE: begin
                nxt_commit = (i_time != i_snap);
                nxt_snap   = i_time;
            end
            OP_DISCARD: nxt_snap = i_time;
            default: nxt_time = i_time;
        endcase
    end

    assign o_step.tm      = nxt_time;
    assign o_step.snap    = nxt_snap;
    assign o_step.sel     = nxt_sel;
    assign o_step.commit  = nxt_commit;
    assign o_step.differs = (nxt_time != nxt_snap);

endmodule

### hdl/date_time_field_editor_core.sv
// Top level of the date and time field editor: state, limits and result register.
// Edits a calendar time (hour, minute, second, date, month, two-digit year standing
// for 2000 + year) one command beat at a time: select a field, step it up or down
// with wrap-around, load a fresh time, save or discard. Every command beat yields
// exactly one result beat carrying the time and selection after the command, a
// changed flag against the snapshot taken at the last load, save or discard, and
// a commit flag raised by a save that found a change. The edit, date clamp and
// snapshot compare sit in one combinational pass between the state registers and
// the result register, so a new command is taken every cycle while the result side
// is ready. The result register holds a beat the sink has not taken; the command
// side stalls only while that beat is held.
// Wrap limits are written through the plain write port (index 0 hour_max to 7
// year_max) and must only be changed while no command is in flight. Reset clears
// the time, snapshot and selection to zero and returns the limits to 23, 59, 59,
// 1, 1, 12, 0 and 99.
`include "date_time_field_editor_core_defines.svh"

module date_time_field_editor_core
    import dtfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dtfe_in_if.sink               i_in,
    dtfe_out_if.source            o_out
);

    t_limits    r_lim;
    t_time      r_time;
    t_time      r_snap;
    logic [2:0] r_sel;
    logic       r_out_valid;
    t_step      r_out;

    t_cmd       cmd;
    t_step      step;
    logic       in_fire;

    // Free the command side whenever the result slot is empty or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign cmd.opcode       = i_in.opcode;
    assign cmd.field_select = i_in.field_select;
    assign cmd.load.hour    = i_in.load_hour;
    assign cmd.load.minute  = i_in.load_minute;
    assign cmd.load.second  = i_in.load_second;
    assign cmd.load.date    = i_in.load_date;
    assign cmd.load.month   = i_in.load_month;
    assign cmd.load.year    = i_in.load_year;

    dtfe_edit u_edit (
        .i_cmd  (cmd),
        .i_time (r_time),
        .i_snap (r_snap),
        .i_sel  (r_sel),
        .i_lim  (r_lim),
        .o_step (step)
    );

    // Limit registers: truncate the write data to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.hour_max   <= 5'd23;
            r_lim.minute_max <= 6'd59;
            r_lim.second_max <= 6'd59;
            r_lim.date_min   <= 5'd1;
            r_lim.month_min  <= 4'd1;
            r_lim.month_max  <= 4'd12;
            r_lim.year_min   <= 7'd0;
            r_lim.year_max   <= 7'd99;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HOUR_MAX:   r_lim.hour_max   <= i_cfg_data[4:0];
                CFG_MINUTE_MAX: r_lim.minute_max <= i_cfg_data[5:0];
                CFG_SECOND_MAX: r_lim.second_max <= i_cfg_data[5:0];
                CFG_DATE_MIN:   r_lim.date_min   <= i_cfg_data[4:0];
                CFG_MONTH_MIN:  r_lim.month_min  <= i_cfg_data[3:0];
                CFG_MONTH_MAX:  r_lim.month_max  <= i_cfg_data[3:0];
                CFG_YEAR_MIN:   r_lim.year_min   <= i_cfg_data[6:0];
                CFG_YEAR_MAX:   r_lim.year_max   <= i_cfg_data[6:0];
                default:        r_lim            <= r_lim;
            endcase
        end
    end

    // Editor state: advance on every accepted command beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_snap <= '0;
            r_sel  <= FLD_NONE;
        end else if (in_fire) begin
            r_time <= step.tm;
            r_snap <= step.snap;
            r_sel  <= step.sel;
        end
    end

    // Result slot: load on a command beat, drop once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= step;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cur_hour   = r_out.tm.hour;
    assign o_out.cur_minute = r_out.tm.minute;
    assign o_out.cur_second = r_out.tm.second;
    assign o_out.cur_date   = r_out.tm.date;
    assign o_out.cur_month  = r_out.tm.month;
    assign o_out.cur_year   = r_out.tm.year;
    assign o_out.cur_field  = r_out.sel;
    assign o_out.differs    = r_out.differs;
    assign o_out.commit     = r_out.commit;

    // A held result always describes the live state: both change on the same beat.
    `DTFE_ASSERT_IMP(a_differs_tracks_state, i_clk, i_rst_n, r_out_valid, (r_out.differs == (r_time != r_snap)) && (r_out.tm == r_time))
    // A save that commits also refreshes the snapshot, so the time reads unchanged.
    `DTFE_ASSERT_IMP(a_commit_clears_differs, i_clk, i_rst_n, r_out_valid && r_out.commit, !r_out.differs)
    // A load clears the selection and matches the snapshot.
    `DTFE_ASSERT_NXT(a_load_resets_edit, i_clk, i_rst_n, in_fire && (i_in.opcode == OP_LOAD), r_out_valid && !r_out.differs && (r_sel == FLD_NONE))
    // A month step never leaves the date beyond the new month length.
    `DTFE_ASSERT_NXT(a_month_step_clamps, i_clk, i_rst_n, in_fire && (r_sel == FLD_MONTH) && ((i_in.opcode == OP_INC) || (i_in.opcode == OP_DEC)), r_time.date <= month_len(r_time.month, r_time.year))

endmodule
